@@ rtl/bdg_pkg.sv @@
// Shared types and constants for the button debounce / gear pulser unit.
// No dependencies; imported by every module of the block.
package bdg_pkg;

   localparam int BUTTONS_DEF   = 16;
   localparam int MAX_GEARS_DEF = 8;
   localparam int TIME_BITS_DEF = 64;

   localparam int WORD_W  = 16;
   localparam int GEAR_W  = 4;
   localparam int CNT_W   = 5;
   localparam int OWED_W  = 8;
   localparam int HIST_W  = 8;
   localparam int PMS_W   = 16;
   localparam int LEN_W   = 26;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam logic [HIST_W-1:0] HIST_ALL  = 8'hFF;
   localparam logic [HIST_W-1:0] HIST_NONE = 8'h00;
   localparam logic [LEN_W-1:0]  US_PER_MS = 26'd1000;

   typedef enum logic [2:0] {
      REG_ENABLE    = 3'd0,
      REG_ACT_LOW   = 3'd1,
      REG_MODE      = 3'd2,
      REG_GEAR_FST  = 3'd3,
      REG_GEAR_CNT  = 3'd4,
      REG_UP_BTN    = 3'd5,
      REG_DOWN_BTN  = 3'd6,
      REG_PULSE_MS  = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_HOLD  = 2'd1,
      MODE_PULSE = 2'd2,
      MODE_SEQ   = 2'd3
   } gear_mode_type;

   typedef struct packed {
      gear_mode_type     mode;
      logic [GEAR_W-1:0] first;
      logic [CNT_W-1:0]  count;
      logic [7:0]        up;
      logic [7:0]        down;
   } gear_cfg_type;

   typedef struct packed {
      logic             accept;
      logic             enable;
      logic             active_low;
      logic             level;
      logic             prev_bit;
      logic             gb_on;
      logic [CNT_W-1:0] count;
   } lane_ctl_type;

   typedef struct packed {
      logic deb;
      logic active;
   } lane_sts_type;

endpackage

@@ rtl/button_debounce_gear_pulser_unit.sv @@
// Top level: CSR block, button lanes, gearbox merge stage and result register.
// Depends on bdg_pkg, bdg_lane and bdg_gear.
// rsp_tvalid is registered on each transfer; one poll per cycle while rsp_tready.
// The stored button word and pulse state update in the same cycle as the transfer.
// Reset (synchronous, active high) clears CSRs, histories, pulses and gear memory.
module button_debounce_gear_pulser_unit #(
   parameter int BUTTONS   = bdg_pkg::BUTTONS_DEF,
   parameter int MAX_GEARS = bdg_pkg::MAX_GEARS_DEF,
   parameter int TIME_BITS = bdg_pkg::TIME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [79:0]                 req_tdata,   // raw_levels[15:0], now_us[79:16]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,   // buttons[15:0]
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bdg_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [bdg_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [bdg_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import bdg_pkg::*;

   logic [WORD_W-1:0]    enable_ff, alow_ff;
   gear_mode_type        mode_ff;
   logic [GEAR_W-1:0]    first_ff;
   logic [CNT_W-1:0]     gcnt_ff;
   logic [7:0]           up_ff, down_ff;
   logic [PMS_W-1:0]     pms_ff;
   logic [TIME_BITS-1:0] len_ff;
   logic                 csr_wr;
   reg_index_type        widx;

   logic [BUTTONS-1:0]   word_ff;
   logic [WORD_W-1:0]    rsp_ff;
   logic                 rsp_valid_ff;
   logic                 accept;
   logic [TIME_BITS-1:0] now, now_len, now_len2;
   logic [BUTTONS-1:0]   deb, active, word;
   logic                 gb_on;
   logic [CNT_W-1:0]     counts [BUTTONS];
   lane_sts_type         sts [BUTTONS];
   gear_cfg_type         gcfg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign widx       = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         alow_ff   <= '0;
         mode_ff   <= MODE_OFF;
         first_ff  <= '0;
         gcnt_ff   <= '0;
         up_ff     <= '0;
         down_ff   <= '0;
         pms_ff    <= '0;
         len_ff    <= '0;
      end else if (csr_wr) begin
         case (widx)
            REG_ENABLE:   enable_ff <= csr_pwdata[WORD_W-1:0];
            REG_ACT_LOW:  alow_ff   <= csr_pwdata[WORD_W-1:0];
            REG_MODE:     mode_ff   <= gear_mode_type'(csr_pwdata[1:0]);
            REG_GEAR_FST: first_ff  <= csr_pwdata[GEAR_W-1:0];
            REG_GEAR_CNT: gcnt_ff   <= csr_pwdata[CNT_W-1:0];
            REG_UP_BTN:   up_ff     <= csr_pwdata[7:0];
            REG_DOWN_BTN: down_ff   <= csr_pwdata[7:0];
            REG_PULSE_MS: begin
               pms_ff <= csr_pwdata[PMS_W-1:0];
               len_ff <= TIME_BITS'(LEN_W'(csr_pwdata[PMS_W-1:0]) * US_PER_MS);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_ENABLE:   csr_prdata = CSR_DW'(enable_ff);
         REG_ACT_LOW:  csr_prdata = CSR_DW'(alow_ff);
         REG_MODE:     csr_prdata = CSR_DW'(mode_ff);
         REG_GEAR_FST: csr_prdata = CSR_DW'(first_ff);
         REG_GEAR_CNT: csr_prdata = CSR_DW'(gcnt_ff);
         REG_UP_BTN:   csr_prdata = CSR_DW'(up_ff);
         REG_DOWN_BTN: csr_prdata = CSR_DW'(down_ff);
         REG_PULSE_MS: csr_prdata = CSR_DW'(pms_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign gcfg = '{mode: mode_ff, first: first_ff, count: gcnt_ff,
                   up: up_ff, down: down_ff};

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign now        = req_tdata[WORD_W +: TIME_BITS];
   assign now_len    = now + len_ff;
   assign now_len2   = now + (len_ff << 1);

   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      lane_ctl_type ctl;
      assign ctl = '{accept: accept, enable: enable_ff[g], active_low: alow_ff[g],
                     level: req_tdata[g], prev_bit: word_ff[g], gb_on: gb_on,
                     count: counts[g]};
      bdg_lane #(.TIME_BITS(TIME_BITS)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .now      (now),
         .len      (len_ff),
         .now_len  (now_len),
         .now_len2 (now_len2),
         .sts      (sts[g])
      );
      assign deb[g]    = sts[g].deb;
      assign active[g] = sts[g].active;
   end

   bdg_gear #(.BUTTONS(BUTTONS), .MAX_GEARS(MAX_GEARS)) u_gear (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (gcfg),
      .deb    (deb),
      .active (active),
      .gb_on  (gb_on),
      .counts (counts),
      .word   (word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            word_ff      <= word;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= WORD_W'(word);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff) else $error("transfer produced no result");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff) else $error("input stalled while output empty");
   a_word_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff == WORD_W'(word_ff)) else $error("result differs from state");

endmodule

@@ rtl/bdg_lane.sv @@
// One button lane: 8-poll debounce history and timed pulse queue.
// Depends on bdg_pkg.
module bdg_lane #(
   parameter int TIME_BITS = bdg_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bdg_pkg::lane_ctl_type ctl,
   input  logic [TIME_BITS-1:0] now,
   input  logic [TIME_BITS-1:0] len,
   input  logic [TIME_BITS-1:0] now_len,
   input  logic [TIME_BITS-1:0] now_len2,
   output bdg_pkg::lane_sts_type sts
);
   import bdg_pkg::*;

   logic [HIST_W-1:0]    hist_ff, hist_in;
   logic [TIME_BITS-1:0] end_ff, end_in, next_ff, next_in;
   logic [OWED_W-1:0]    owed_ff, owed_in;
   logic [TIME_BITS-1:0] q_end, q_next;
   logic [OWED_W-1:0]    q_owed;
   logic                 pressed;
   logic                 deb_bit, act_bit;

   always_comb begin
      pressed = ctl.level ^ ctl.active_low;
      hist_in = hist_ff;
      deb_bit = 1'b0;
      if (ctl.enable) begin
         hist_in = {hist_ff[HIST_W-2:0], pressed};
         if (hist_in == HIST_ALL) begin
            deb_bit = 1'b1;
         end else if (hist_in == HIST_NONE) begin
            deb_bit = 1'b0;
         end else begin
            deb_bit = ctl.prev_bit;
         end
      end
   end

   always_comb begin
      q_end  = end_ff;
      q_next = next_ff;
      q_owed = owed_ff;
      if (ctl.count != '0) begin
         if (end_ff > now) begin
            q_owed = owed_ff + OWED_W'(ctl.count);
            q_next = end_ff + len;
         end else begin
            q_end = now_len;
            if (ctl.count > CNT_W'(1)) begin
               q_owed = OWED_W'(ctl.count - CNT_W'(1));
               q_next = now_len2;
            end
         end
      end
      end_in  = q_end;
      next_in = q_next;
      owed_in = q_owed;
      if (q_owed != '0 && now >= q_next) begin
         end_in  = now_len;
         owed_in = q_owed - OWED_W'(1);
         if (owed_in != '0) begin
            next_in = now_len2;
         end
      end
      act_bit = end_in > now;
   end

   assign sts = '{deb: deb_bit, active: act_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         end_ff  <= '0;
         next_ff <= '0;
         owed_ff <= '0;
      end else if (ctl.accept) begin
         hist_ff <= hist_in;
         if (ctl.gb_on) begin
            end_ff  <= end_in;
            next_ff <= next_in;
            owed_ff <= owed_in;
         end
      end
   end

endmodule

@@ rtl/bdg_gear.sv @@
// Gearbox merge stage: finds the engaged gear, hands pulse requests to the
// lanes and merges their pulse outputs into the button word. Depends on bdg_pkg.
module bdg_gear #(
   parameter int BUTTONS   = bdg_pkg::BUTTONS_DEF,
   parameter int MAX_GEARS = bdg_pkg::MAX_GEARS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  bdg_pkg::gear_cfg_type       cfg,
   input  logic [BUTTONS-1:0]          deb,
   input  logic [BUTTONS-1:0]          active,
   output logic                        gb_on,
   output logic [bdg_pkg::CNT_W-1:0]   counts [BUTTONS],
   output logic [BUTTONS-1:0]          word
);
   import bdg_pkg::*;

   logic              lg_valid_ff, lg_valid_in;
   logic [GEAR_W-1:0] lg_ff, lg_in;
   logic [BUTTONS-1:0] range, gears, onehot;
   logic              found, change;
   logic [CNT_W-1:0]  cur;
   logic [GEAR_W-1:0] cur4, steps;
   logic [7:0]        tgt;
   logic [CNT_W-1:0]  idx;

   always_comb begin
      gb_on = cfg.mode != MODE_OFF && cfg.count >= CNT_W'(2)
              && cfg.count <= CNT_W'(MAX_GEARS)
              && ({2'b0, cfg.first} + {1'b0, cfg.count}) <= 6'(BUTTONS);
      for (int i = 0; i < BUTTONS; i++) begin
         range[i] = (5'(i) >= {1'b0, cfg.first})
                    && (6'(i) < ({2'b0, cfg.first} + {1'b0, cfg.count}));
      end
      gears  = deb & range;
      found  = |gears;
      onehot = gears & (~gears + BUTTONS'(1));
      cur    = '0;
      for (int i = BUTTONS - 1; i >= 0; i--) begin
         if (gears[i]) begin
            cur = 5'(i) - {1'b0, cfg.first};
         end
      end
      cur4   = cur[GEAR_W-1:0];
      change = found && (!lg_valid_ff || cur4 != lg_ff);
      if (cur4 > lg_ff) begin
         steps = cur4 - lg_ff;
         tgt   = cfg.up;
      end else begin
         steps = lg_ff - cur4;
         tgt   = cfg.down;
      end
      idx = {1'b0, cfg.first} + {1'b0, cur4};
      for (int i = 0; i < BUTTONS; i++) begin
         counts[i] = '0;
         if (gb_on && change) begin
            if (cfg.mode == MODE_SEQ && lg_valid_ff && tgt == 8'(i)) begin
               counts[i] = CNT_W'(steps);
            end else if (cfg.mode == MODE_PULSE && idx == 5'(i)) begin
               counts[i] = CNT_W'(1);
            end
         end
      end
      lg_valid_in = lg_valid_ff;
      lg_in       = lg_ff;
      if (gb_on && change) begin
         lg_valid_in = 1'b1;
         lg_in       = cur4;
      end
      if (gb_on) begin
         word = (deb & ~range) | active | ((cfg.mode == MODE_HOLD) ? onehot : '0);
      end else begin
         word = deb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_valid_ff <= 1'b0;
         lg_ff       <= '0;
      end else if (accept) begin
         lg_valid_ff <= lg_valid_in;
         lg_ff       <= lg_in;
      end
   end

   a_lg_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(lg_valid_ff) |-> lg_valid_ff) else $error("gear memory lost");
   a_bypass_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !gb_on |=> $stable(lg_ff) && $stable(lg_valid_ff))
      else $error("gear changed while bypassed");
   a_hold_one: assert property (@(posedge clock) disable iff (reset)
      $countones(onehot) <= 1) else $error("more than one gear selected");

endmodule
